/* src/mceb_pkg.sv */
// Shared constants, types and a helper function of the multi-chip event builder.
package mceb_pkg;

    // Sizing of the chip array and of the word counters
    localparam int CHIPS          = 16;
    localparam int WORD_COUNT_MAX = 4095;
    localparam int MASK_W         = 16;
    localparam int LINK_W         = 5;
    localparam int LINKS_RESET    = 1;
    localparam int WIDE_W         = 16;
    localparam int MAX_OUT_W      = 12;

    localparam int CNT_W      = $clog2(WORD_COUNT_MAX + 1);
    localparam int TOTAL_W    = $clog2(CHIPS * WORD_COUNT_MAX + 1);
    localparam int CHIP_IDX_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;
    localparam int SEQ_W      = $clog2(((CHIPS > TOTAL_W) ? CHIPS : TOTAL_W) + 1);
    localparam int TOT_EXT_W  = (TOTAL_W > WIDE_W) ? TOTAL_W : WIDE_W;
    localparam int MAX_EXT_W  = (CNT_W > MAX_OUT_W) ? CNT_W : MAX_OUT_W;

    typedef logic [CNT_W-1:0] count_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  step;
        logic                  sum_en;
        logic                  sum_last;
        logic                  div_en;
        logic                  finish;
        logic [CHIP_IDX_W-1:0] chip_idx;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic evt_release;
    } status_t;

    // Saturating increment of a word counter
    function automatic count_t sat_inc(count_t v);
        return (v >= count_t'(WORD_COUNT_MAX)) ? count_t'(WORD_COUNT_MAX) : v + count_t'(1);
    endfunction

endpackage

/* src/mceb_ifs.sv */
// Channel interfaces of the event builder: tick input, result output, configuration write.
interface mceb_tick_if;
    logic                         valid;
    logic                         ready;
    logic [mceb_pkg::MASK_W-1:0]  data_valid_mask;
    logic [mceb_pkg::MASK_W-1:0]  control_valid_mask;
    logic [mceb_pkg::MASK_W-1:0]  control_header_mask;

    modport source (output valid, output data_valid_mask, output control_valid_mask,
                    output control_header_mask, input ready);
    modport sink   (input valid, input data_valid_mask, input control_valid_mask,
                    input control_header_mask, output ready);
endinterface

interface mceb_result_if;
    logic                            valid;
    logic                            ready;
    logic [mceb_pkg::MASK_W-1:0]     read_data_mask;
    logic [mceb_pkg::MASK_W-1:0]     read_control_mask;
    logic                            event_ready;
    logic [mceb_pkg::WIDE_W-1:0]     event_words;
    logic [mceb_pkg::WIDE_W-1:0]     send_ticks;
    logic [mceb_pkg::MAX_OUT_W-1:0]  max_chip_words;
    logic                            count_error;

    modport source (output valid, output read_data_mask, output read_control_mask,
                    output event_ready, output event_words, output send_ticks,
                    output max_chip_words, output count_error, input ready);
    modport sink   (input valid, input read_data_mask, input read_control_mask,
                    input event_ready, input event_words, input send_ticks,
                    input max_chip_words, input count_error, output ready);
endinterface

interface mceb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mceb_pkg::LINK_W-1:0]  link_count;

    modport source (output valid, output link_count, input ready);
    modport sink   (input valid, input link_count, output ready);
endinterface

/* src/mceb_ctrl.sv */
// Controller state machine: tick handshake, event summing and division sequencing.
module mceb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    output logic              tick_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  mceb_pkg::status_t status,
    output mceb_pkg::cmd_t    cmd
);
    import mceb_pkg::*;

    state_t           state_reg, state_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;
    logic             load_result;

    // Take a beat only when idle and the result slot is free or draining
    assign out_free     = !out_valid_reg || result_ready;
    assign tick_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept       = tick_valid && tick_ready;
    assign result_valid = out_valid_reg;

    // Sequence the event release
    always_comb
    begin
        state_next   = state_reg;
        seq_next     = seq_reg;
        cmd          = '0;
        cmd.chip_idx = seq_reg[CHIP_IDX_W-1:0];
        load_result  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.step = accept;
                if (accept)
                begin
                    if (status.evt_release)
                    begin
                        state_next = ST_SUM;
                        seq_next   = '0;
                    end
                    else
                    begin
                        load_result = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                if (seq_reg == SEQ_W'(CHIPS - 1))
                begin
                    cmd.sum_last = 1'b1;
                    state_next   = ST_DIV;
                    seq_next     = '0;
                end
                else
                begin
                    seq_next = seq_reg + SEQ_W'(1);
                end
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                if (seq_reg == SEQ_W'(TOTAL_W - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    seq_next = seq_reg + SEQ_W'(1);
                end
            end
            ST_DONE:
            begin
                cmd.finish  = 1'b1;
                load_result = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb
    begin
        if (load_result)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/mceb_datapath.sv */
// Datapath: per-chip counters, request masks, event sum, maximum and send-time divider.
module mceb_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mceb_pkg::cmd_t                    cmd,
    output mceb_pkg::status_t                 status,
    input  logic [mceb_pkg::MASK_W-1:0]       data_valid_mask,
    input  logic [mceb_pkg::MASK_W-1:0]       control_valid_mask,
    input  logic [mceb_pkg::MASK_W-1:0]       control_header_mask,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mceb_pkg::LINK_W-1:0]       link_count,
    output logic [mceb_pkg::MASK_W-1:0]       read_data_mask,
    output logic [mceb_pkg::MASK_W-1:0]       read_control_mask,
    output logic                              event_ready,
    output logic [mceb_pkg::WIDE_W-1:0]       event_words,
    output logic [mceb_pkg::WIDE_W-1:0]       send_ticks,
    output logic [mceb_pkg::MAX_OUT_W-1:0]    max_chip_words,
    output logic                              count_error
);
    import mceb_pkg::*;

    // Per-chip state
    count_t             pend_reg [CHIPS];
    count_t             buf_reg  [CHIPS];
    logic [CHIPS-1:0]   comp_reg;
    logic [CHIPS-1:0]   hdr_reg;
    logic [CHIPS-1:0]   rdp_reg;
    logic [CHIPS-1:0]   rcp_reg;

    // Per-chip next values for one tick
    count_t             pend_step [CHIPS];
    count_t             buf_step  [CHIPS];
    logic [CHIPS-1:0]   comp_step;
    logic [CHIPS-1:0]   hdr_step;
    logic [CHIPS-1:0]   rd_step;
    logic [CHIPS-1:0]   rc_step;
    logic [CHIPS-1:0]   err_vec;
    logic [CHIPS-1:0]   done_vec;

    logic [WIDE_W-1:0]  timer_reg;
    logic [WIDE_W-1:0]  timer_dec;
    logic [LINK_W-1:0]  links_reg;

    // Event summary and divider
    logic [TOTAL_W-1:0] acc_reg;
    logic [TOTAL_W-1:0] acc_next;
    count_t             max_reg;
    count_t             max_next;
    count_t             buf_sel;
    logic [TOTAL_W-1:0] quo_reg;
    logic [LINK_W-1:0]  rem_reg;
    logic [LINK_W:0]    rem_trial;
    logic               quo_bit;

    logic [MASK_W-1:0]  rd_mask_w;
    logic [MASK_W-1:0]  rc_mask_w;
    logic [TOT_EXT_W-1:0] tot_ext;
    logic [TOT_EXT_W-1:0] quo_ext;
    logic [MAX_EXT_W-1:0] max_ext;
    logic [WIDE_W-1:0]  words_sat;
    logic [WIDE_W-1:0]  ticks_sat;
    logic [MAX_OUT_W-1:0] max_sat;

    assign cfg_ready = 1'b1;

    // Count the send timer down
    assign timer_dec = (timer_reg != '0) ? timer_reg - WIDE_W'(1) : '0;

    // Advance each chip by one tick: data first, then control, then requests
    for (genvar c = 0; c < CHIPS; c++)
    begin : g_chip
        logic dv;
        logic cv;
        logic hb;

        if (c < MASK_W)
        begin : g_in
            assign dv = data_valid_mask[c];
            assign cv = control_valid_mask[c];
            assign hb = control_header_mask[c];
        end
        else
        begin : g_none
            assign dv = 1'b0;
            assign cv = 1'b0;
            assign hb = 1'b0;
        end

        always_comb
        begin
            count_t pend_d;
            pend_d       = pend_reg[c];
            buf_step[c]  = buf_reg[c];
            comp_step[c] = comp_reg[c];
            hdr_step[c]  = hdr_reg[c];
            err_vec[c]   = 1'b0;
            if (dv)
            begin
                buf_step[c] = sat_inc(buf_reg[c]);
                if (pend_reg[c] == '0)
                    err_vec[c] = 1'b1;
                else
                    pend_d = pend_reg[c] - count_t'(1);
            end
            if (cv)
            begin
                if (comp_reg[c])
                    err_vec[c] = 1'b1;
                if (hb && (buf_step[c] != '0))
                begin
                    comp_step[c] = 1'b1;
                    hdr_step[c]  = 1'b1;
                end
                else
                begin
                    pend_d = sat_inc(pend_d);
                end
            end
            pend_step[c] = pend_d;
            rd_step[c]   = (pend_d > count_t'(1)) || ((pend_d == count_t'(1)) && !rdp_reg[c]);
            rc_step[c]   = !comp_step[c] && !rcp_reg[c];
            done_vec[c]  = comp_step[c] && (pend_d == '0);
        end
    end

    // Map chips onto the request masks
    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < CHIPS)
        begin : g_bit
            assign rd_mask_w[m] = rd_step[m];
            assign rc_mask_w[m] = rc_step[m];
        end
        else
        begin : g_zero
            assign rd_mask_w[m] = 1'b0;
            assign rc_mask_w[m] = 1'b0;
        end
    end

    assign status.evt_release = (&done_vec) && (timer_dec == '0);

    // Accumulate total and maximum one chip per cycle
    assign buf_sel  = buf_reg[cmd.chip_idx];
    assign acc_next = acc_reg + TOTAL_W'(buf_sel);
    assign max_next = (buf_sel > max_reg) ? buf_sel : max_reg;

    // Restoring division, one quotient bit per cycle
    assign rem_trial = {rem_reg, quo_reg[TOTAL_W-1]};
    assign quo_bit   = (rem_trial >= {1'b0, links_reg});

    // Saturate the event summary to the output widths
    assign tot_ext   = TOT_EXT_W'(acc_reg);
    assign quo_ext   = TOT_EXT_W'(quo_reg);
    assign max_ext   = MAX_EXT_W'(max_reg);
    assign words_sat = (tot_ext > TOT_EXT_W'({WIDE_W{1'b1}})) ? {WIDE_W{1'b1}}
                                                              : tot_ext[WIDE_W-1:0];
    assign ticks_sat = (links_reg == '0) ? '0
                     : (quo_ext > TOT_EXT_W'({WIDE_W{1'b1}})) ? {WIDE_W{1'b1}}
                                                              : quo_ext[WIDE_W-1:0];
    assign max_sat   = (max_ext > MAX_EXT_W'({MAX_OUT_W{1'b1}})) ? {MAX_OUT_W{1'b1}}
                                                                 : max_ext[MAX_OUT_W-1:0];

    // Chip state, timer and link count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHIPS; c++)
            begin
                pend_reg[c] <= '0;
                buf_reg[c]  <= '0;
            end
            comp_reg  <= '0;
            hdr_reg   <= '0;
            rdp_reg   <= '0;
            rcp_reg   <= '0;
            timer_reg <= '0;
            links_reg <= LINK_W'(LINKS_RESET);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                links_reg <= link_count;
            if (cmd.step)
            begin
                for (int c = 0; c < CHIPS; c++)
                begin
                    pend_reg[c] <= pend_step[c];
                    buf_reg[c]  <= buf_step[c];
                end
                comp_reg  <= comp_step;
                hdr_reg   <= hdr_step;
                rdp_reg   <= rd_step;
                rcp_reg   <= rc_step;
                timer_reg <= timer_dec;
            end
            else if (cmd.finish)
            begin
                // Clear all chips and turn held headers into pending words
                for (int c = 0; c < CHIPS; c++)
                begin
                    buf_reg[c] <= '0;
                    if (hdr_reg[c])
                        pend_reg[c] <= sat_inc(pend_reg[c]);
                end
                comp_reg  <= '0;
                hdr_reg   <= '0;
                timer_reg <= ticks_sat;
            end
        end
    end

    // Event summary and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            acc_reg <= '0;
            max_reg <= '0;
        end
        else if (cmd.sum_en)
        begin
            acc_reg <= acc_next;
            max_reg <= max_next;
        end
        if (cmd.sum_last)
        begin
            quo_reg <= acc_next;
            rem_reg <= '0;
        end
        else if (cmd.div_en)
        begin
            quo_reg <= {quo_reg[TOTAL_W-2:0], quo_bit};
            rem_reg <= quo_bit ? LINK_W'(rem_trial - {1'b0, links_reg})
                               : rem_trial[LINK_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            read_data_mask    <= rd_mask_w;
            read_control_mask <= rc_mask_w;
            count_error       <= |err_vec;
            event_ready       <= 1'b0;
            event_words       <= '0;
            send_ticks        <= '0;
            max_chip_words    <= '0;
        end
        else if (cmd.finish)
        begin
            event_ready    <= 1'b1;
            event_words    <= words_sat;
            send_ticks     <= ticks_sat;
            max_chip_words <= max_sat;
        end
    end

endmodule

/* src/multi_chip_event_builder.sv */
// Top level of the multi-chip event builder: controller, datapath and checks.
//
// One tick beat advances every chip's pending and buffered word counts and
// yields one result beat with that tick's read requests. For a tick that
// releases an event (sixteen chips of 12-bit counts), the datapath adds and
// compares the buffered counts one chip per cycle, then a restoring divider
// computes the send time one quotient bit per cycle, then the chips are
// cleared. No tick is taken during that time. The output register holds a
// result beat while the next tick is taken in the same cycle that the result
// is consumed. The user must see that link_count is written only while the
// block is idle; the block itself does not enforce this.
module multi_chip_event_builder (
    input  logic                 clk,
    input  logic                 rst_n,
    mceb_tick_if.sink            tick,
    mceb_result_if.source        result,
    mceb_cfg_if.sink             cfg
);
    import mceb_pkg::*;

    cmd_t    cmd;
    status_t status;

    mceb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick.valid),
        .tick_ready   (tick.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    mceb_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .data_valid_mask     (tick.data_valid_mask),
        .control_valid_mask  (tick.control_valid_mask),
        .control_header_mask (tick.control_header_mask),
        .cfg_valid           (cfg.valid),
        .cfg_ready           (cfg.ready),
        .link_count          (cfg.link_count),
        .read_data_mask      (result.read_data_mask),
        .read_control_mask   (result.read_control_mask),
        .event_ready         (result.event_ready),
        .event_words         (result.event_words),
        .send_ticks          (result.send_ticks),
        .max_chip_words      (result.max_chip_words),
        .count_error         (result.count_error)
    );

    // Only one datapath operation per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.step, cmd.sum_en, cmd.div_en, cmd.finish}))
        else $error("more than one datapath command in a cycle");

    // No tick beat is taken while an event is being summed or divided
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sum_en || cmd.div_en || cmd.finish) |-> !tick.ready)
        else $error("tick accepted during event release");

    // The release result lands in an empty output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !result.valid)
        else $error("release result overwrites a pending result beat");

    // The last summing cycle is followed by the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_last |=> cmd.div_en)
        else $error("divider did not start after summing");

endmodule

/* tb/mceb_result_checker.sv */
// Result checker of the multi-chip event builder: per-tick prediction and beat comparison.
module mceb_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    mceb_tick_if        tick_mon,
    mceb_result_if      result_mon,
    mceb_cfg_if         cfg_mon,
    output int unsigned mismatches,
    output int unsigned results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import mceb_pkg::*;

    // One predicted result beat
    typedef struct packed {
        logic [MASK_W-1:0]    read_data;
        logic [MASK_W-1:0]    read_control;
        logic                 ready;
        logic [WIDE_W-1:0]    words;
        logic [WIDE_W-1:0]    ticks;
        logic [MAX_OUT_W-1:0] max_words;
        logic                 error;
    } tick_result_t;

    // Own copy of the chip state and of the link setting
    count_t              pending_cnt  [CHIPS];
    count_t              buffered_cnt [CHIPS];
    logic [CHIPS-1:0]    complete;
    logic [CHIPS-1:0]    header_seen;
    logic [CHIPS-1:0]    data_req_last;
    logic [CHIPS-1:0]    ctrl_req_last;
    logic [WIDE_W-1:0]   drain_timer;
    logic [LINK_W-1:0]   links;
    tick_result_t        tick_results_due [$];

    // Count up, hold at the top
    function automatic count_t bump(count_t v);
        if (v == count_t'(WORD_COUNT_MAX))
            return v;
        return count_t'(v + 1'b1);
    endfunction

    // Advance every chip by one tick and build the result beat it yields
    function automatic tick_result_t predict_tick(logic [MASK_W-1:0] dv,
                                                 logic [MASK_W-1:0] cv,
                                                 logic [MASK_W-1:0] hd);
        tick_result_t r;
        logic         all_done;
        logic         rd;
        logic         rc;
        int unsigned  total;
        int unsigned  peak;
        int unsigned  quot;
        r        = '0;
        all_done = 1'b1;
        if (drain_timer != 0)
            drain_timer--;

        for (int c = 0; c < CHIPS; c++) begin
            // data first: buffer the word, retire one pending word
            if (c < MASK_W && dv[c]) begin
                buffered_cnt[c] = bump(buffered_cnt[c]);
                if (pending_cnt[c] == 0)
                    r.error = 1'b1;
                else
                    pending_cnt[c] = pending_cnt[c] - 1'b1;
            end
            // then control: a header closes the chip once it holds words
            if (c < MASK_W && cv[c]) begin
                if (complete[c])
                    r.error = 1'b1;
                if (hd[c] && buffered_cnt[c] != 0) begin
                    complete[c]    = 1'b1;
                    header_seen[c] = 1'b1;
                end
                else begin
                    pending_cnt[c] = bump(pending_cnt[c]);
                end
            end
            // read requests, never twice in a row on the last word
            rd = (pending_cnt[c] > 1) || (pending_cnt[c] == 1 && !data_req_last[c]);
            data_req_last[c] = rd;
            rc = !complete[c] && !ctrl_req_last[c];
            ctrl_req_last[c] = rc;
            if (c < MASK_W) begin
                r.read_data[c]    = rd;
                r.read_control[c] = rc;
            end
            if (!complete[c] || pending_cnt[c] != 0)
                all_done = 1'b0;
        end

        // release the event: report its size, load the timer, clear the chips
        if (all_done && drain_timer == 0) begin
            total = 0;
            peak  = 0;
            for (int c = 0; c < CHIPS; c++) begin
                total += buffered_cnt[c];
                if (buffered_cnt[c] > peak)
                    peak = 32'(buffered_cnt[c]);
            end
            quot = (links != 0) ? total / links : 0;
            if (quot > 32'hFFFF)
                quot = 32'hFFFF;
            drain_timer = quot[WIDE_W-1:0];
            r.ready     = 1'b1;
            r.words     = (total > 32'hFFFF) ? '1 : total[WIDE_W-1:0];
            r.ticks     = quot[WIDE_W-1:0];
            r.max_words = (peak > 32'hFFF) ? '1 : peak[MAX_OUT_W-1:0];
            for (int c = 0; c < CHIPS; c++) begin
                complete[c]     = 1'b0;
                buffered_cnt[c] = '0;
                if (header_seen[c]) begin
                    header_seen[c] = 1'b0;
                    pending_cnt[c] = bump(pending_cnt[c]);
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // Track configuration, predict on tick beats, compare on result beats
    always @(posedge clk or negedge rst_n) begin : score_beats
        tick_result_t want;
        if (!rst_n) begin
            for (int c = 0; c < CHIPS; c++) begin
                pending_cnt[c]  = '0;
                buffered_cnt[c] = '0;
            end
            complete      = '0;
            header_seen   = '0;
            data_req_last = '0;
            ctrl_req_last = '0;
            drain_timer   = '0;
            links         = LINK_W'(LINKS_RESET);
            mismatches    = 0;
            tick_results_due.delete();
            results_due  <= 0;
        end
        else begin
            if (cfg_mon.valid && cfg_mon.ready)
                links = cfg_mon.link_count;
            if (result_mon.valid && result_mon.ready) begin
                if (tick_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat with no tick beat waiting", $time);
                end
                else begin
                    want = tick_results_due.pop_front();
                    check_field("read_data_mask", 32'(want.read_data),
                                32'(result_mon.read_data_mask));
                    check_field("read_control_mask", 32'(want.read_control),
                                32'(result_mon.read_control_mask));
                    check_field("event_ready", 32'(want.ready),
                                32'(result_mon.event_ready));
                    check_field("event_words", 32'(want.words),
                                32'(result_mon.event_words));
                    check_field("send_ticks", 32'(want.ticks),
                                32'(result_mon.send_ticks));
                    check_field("max_chip_words", 32'(want.max_words),
                                32'(result_mon.max_chip_words));
                    check_field("count_error", 32'(want.error),
                                32'(result_mon.count_error));
                end
            end
            if (tick_mon.valid && tick_mon.ready)
                tick_results_due.push_back(predict_tick(tick_mon.data_valid_mask,
                                                        tick_mon.control_valid_mask,
                                                        tick_mon.control_header_mask));
            results_due <= tick_results_due.size();
        end
    end

endmodule

/* tb/multi_chip_event_builder_tb.sv */
// Testbench top of the multi-chip event builder: clock, reset, stimulus and verdict.
module multi_chip_event_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mceb_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_TICKS  = 320;
    localparam int DRAIN_CYCLES = 40;
    localparam int WAIT_CAP     = 70000;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_CYCLES  = 200;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mceb_tick_if   tick ();
    mceb_result_if result ();
    mceb_cfg_if    cfg ();

    int unsigned mismatches;
    int unsigned results_due;
    int unsigned ticks_sent;
    int unsigned results_taken;
    int unsigned events_seen;
    int unsigned events_planned;
    int unsigned errors_seen;
    int unsigned quiet_cycles;

    // Rough view of the chips, enough to steer the stimulus toward releases
    int unsigned      gen_pending [CHIPS];
    logic [CHIPS-1:0] gen_buffered = '0;
    logic [CHIPS-1:0] gen_complete = '0;
    logic [CHIPS-1:0] gen_header   = '0;

    always #2 clk = ~clk;

    multi_chip_event_builder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .result (result),
        .cfg    (cfg)
    );

    mceb_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_mon    (tick),
        .result_mon  (result),
        .cfg_mon     (cfg),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // Count released events and error beats; stop the run if traffic dies
    always @(posedge clk) begin
        if (rst_n) begin
            if (result.valid && result.ready) begin
                if (result.event_ready)
                    events_seen <= events_seen + 1;
                if (result.count_error)
                    errors_seen <= errors_seen + 1;
            end
            if ((tick.valid && tick.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("** multi_chip_event_builder: FAILED **");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result receiver: random stalls, a steady stretch and one long hold-off
    initial begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                result.ready <= 1'b0;
            end
            else begin
                if (result.valid && result.ready)
                    results_taken <= results_taken + 1;
                if (hold_left != 0) begin
                    hold_left--;
                    result.ready <= 1'b0;
                end
                else if (!hold_done && results_taken == HOLD_AT) begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                    result.ready <= 1'b0;
                end
                else begin
                    result.ready <= (results_taken >= 300 && results_taken < 600) ||
                                    ($urandom_range(99) >= 26);
                end
            end
        end
    end

    // Offer one tick beat, hold it until taken, and update the chip view
    task automatic offer_tick(input logic [MASK_W-1:0] dv, input logic [MASK_W-1:0] cv,
                              input logic [MASK_W-1:0] hd);
        while (!(ticks_sent >= 200 && ticks_sent < 500) && $urandom_range(99) < 26) begin
            tick.valid <= 1'b0;
            @(posedge clk);
        end
        tick.valid               <= 1'b1;
        tick.data_valid_mask     <= dv;
        tick.control_valid_mask  <= cv;
        tick.control_header_mask <= hd;
        @(posedge clk);
        while (!tick.ready)
            @(posedge clk);
        ticks_sent++;
        for (int c = 0; c < CHIPS; c++) begin
            if (dv[c]) begin
                gen_buffered[c] = 1'b1;
                if (gen_pending[c] != 0)
                    gen_pending[c]--;
            end
            if (cv[c]) begin
                if (hd[c] && gen_buffered[c]) begin
                    gen_complete[c] = 1'b1;
                    gen_header[c]   = 1'b1;
                end
                else if (gen_pending[c] < WORD_COUNT_MAX) begin
                    gen_pending[c]++;
                end
            end
        end
    endtask

    // Send a tick; once every chip is closed, send empty ticks until the event is out
    task automatic feed_tick(input logic [MASK_W-1:0] dv, input logic [MASK_W-1:0] cv,
                             input logic [MASK_W-1:0] hd);
        logic        settled;
        int unsigned waited;
        offer_tick(dv, cv, hd);
        settled = &gen_complete;
        for (int c = 0; c < CHIPS; c++)
            if (gen_pending[c] != 0)
                settled = 1'b0;
        if (settled) begin
            events_planned++;
            waited = 0;
            while (events_seen < events_planned && waited < WAIT_CAP) begin
                offer_tick('0, '0, '0);
                waited++;
            end
            if (events_seen < events_planned)
                events_planned = events_seen;
            for (int c = 0; c < CHIPS; c++) begin
                gen_complete[c] = 1'b0;
                gen_buffered[c] = 1'b0;
                if (gen_header[c]) begin
                    gen_header[c] = 1'b0;
                    if (gen_pending[c] < WORD_COUNT_MAX)
                        gen_pending[c]++;
                end
            end
        end
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic wait_drained();
        tick.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic set_links(input logic [LINK_W-1:0] value);
        wait_drained();
        cfg.valid      <= 1'b1;
        cfg.link_count <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned       link_plan [5];
        logic [MASK_W-1:0] dv;
        logic [MASK_W-1:0] cv;
        logic [MASK_W-1:0] hd;
        int unsigned       roll;
        link_plan = '{0, 16, 15, 2, 1};
        for (int c = 0; c < CHIPS; c++)
            gen_pending[c] = 0;
        tick.valid               <= 1'b0;
        tick.data_valid_mask     <= '0;
        tick.control_valid_mask  <= '0;
        tick.control_header_mask <= '0;
        cfg.valid                <= 1'b0;
        cfg.link_count           <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and corner cases at the reset link setting
        feed_tick('0, '0, '0);
        feed_tick('1, '0, '0);                  // data with nothing pending
        feed_tick('0, '1, '0);                  // one pending word per chip
        feed_tick('0, '1, '1);                  // headers close every chip
        feed_tick('0, '1, '0);                  // control for closed chips
        feed_tick('1, '0, '0);
        feed_tick('1, '0, '0);                  // last word retired, event goes out
        feed_tick('0, 16'hF0F0, '1);            // header with nothing buffered
        feed_tick(16'hAAAA, 16'h5555, '0);
        feed_tick(16'h5555, 16'hAAAA, '0);
        feed_tick('1, '0, '1);                  // header bits with no control
        feed_tick('1, '1, '1);                  // data and header on one tick
        feed_tick('1, '0, '0);
        feed_tick('1, '0, '0);
        feed_tick('1, '0, '0);

        // Random phases, one per link setting
        foreach (link_plan[p]) begin
            set_links(LINK_W'(link_plan[p]));
            repeat (PHASE_TICKS) begin
                if ($urandom_range(99) < 15) begin
                    // noise: any mix of bits
                    dv = MASK_W'($urandom);
                    cv = MASK_W'($urandom);
                    hd = MASK_W'($urandom);
                end
                else begin
                    // orderly build: control, then data, then a closing header
                    dv = '0;
                    cv = '0;
                    hd = MASK_W'($urandom);
                    for (int c = 0; c < CHIPS; c++) begin
                        if (gen_pending[c] != 0 && $urandom_range(99) < 55)
                            dv[c] = 1'b1;
                        roll = $urandom_range(99);
                        if (!gen_complete[c]) begin
                            if ((gen_buffered[c] || dv[c]) && gen_pending[c] == dv[c] &&
                                roll < 35) begin
                                cv[c] = 1'b1;
                                hd[c] = 1'b1;
                            end
                            else if (gen_pending[c] < 3 && roll < 60) begin
                                cv[c] = 1'b1;
                                if (gen_buffered[c] || dv[c])
                                    hd[c] = 1'b0;
                            end
                        end
                    end
                end
                feed_tick(dv, cv, hd);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d tick beats, %0d events released, %0d beats with count_error.",
                 ticks_sent, events_seen, errors_seen);
        $display("Links swept over 0, 1, 2, 15 and 16 with directed corner ticks and noise.");
        if (mismatches == 0)
            $display("** multi_chip_event_builder: PASSED **");
        else
            $display("** multi_chip_event_builder: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
src/mceb_pkg.sv
src/mceb_ifs.sv
src/mceb_ctrl.sv
src/mceb_datapath.sv
src/multi_chip_event_builder.sv
tb/mceb_result_checker.sv
tb/multi_chip_event_builder_tb.sv
